// File: rtl/jtbs_pkg.sv
// Package: beat types, token type codes and character codes for the JSON token scanner.
`default_nettype none

package jtbs_pkg;

  localparam int unsigned TokW = 4;

  localparam logic [TokW-1:0] TOK_WS      = 4'd0;
  localparam logic [TokW-1:0] TOK_NL      = 4'd1;
  localparam logic [TokW-1:0] TOK_LBRACK  = 4'd2;
  localparam logic [TokW-1:0] TOK_RBRACK  = 4'd3;
  localparam logic [TokW-1:0] TOK_LBRACE  = 4'd4;
  localparam logic [TokW-1:0] TOK_RBRACE  = 4'd5;
  localparam logic [TokW-1:0] TOK_COLON   = 4'd6;
  localparam logic [TokW-1:0] TOK_COMMA   = 4'd7;
  localparam logic [TokW-1:0] TOK_STR     = 4'd8;
  localparam logic [TokW-1:0] TOK_BSTR    = 4'd9;
  localparam logic [TokW-1:0] TOK_COMM    = 4'd10;
  localparam logic [TokW-1:0] TOK_BCOMM   = 4'd11;
  localparam logic [TokW-1:0] TOK_VALUE   = 4'd12;
  localparam logic [TokW-1:0] TOK_INVALID = 4'd13;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [1:0] QUOTE_SAT  = 2'd3;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_END  = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       mode;
  } in_beat_t;

  typedef struct packed {
    logic [TokW-1:0] token_type;
    logic            ends_before_byte;
    logic            last;
  } out_beat_t;

  function automatic logic ends_value(input logic [7:0] b);
    logic r;
    case (b)
      CH_TAB, CH_LF, CH_CR, CH_SPACE, CH_QUOTE, CH_COMMA, CH_COLON,
      CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/json_token_boundary_scanner_core.sv
// Top level: streaming JSON token boundary scanner with input register and result queue.
//
// One byte beat is taken per cycle while the input is not stalled. Each beat goes
// into an input register, is scanned from it by the token state machine and
// gives zero, one or two result beats into a four-entry result queue; the output
// side drains one result per cycle while out_stall_i is low. A byte that closes
// one token and opens another that closes at once gives two results, and the input
// stalls while the queue holds more than two results. An end-of-input beat closes
// the open token and leaves the scanner idle. A result passes through the input
// register and the result queue before it reaches the output.
`default_nettype none

module json_token_boundary_scanner_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire jtbs_pkg::in_beat_t in_beat_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output jtbs_pkg::out_beat_t     out_beat_o
);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_WS     = 4'd1,
    PH_CR     = 4'd2,
    PH_VALUE  = 4'd3,
    PH_SLASH  = 4'd4,
    PH_LCOMM  = 4'd5,
    PH_BCOMM  = 4'd6,
    PH_BADVAL = 4'd7,
    PH_QUOTES = 4'd8,
    PH_STR    = 4'd9,
    PH_BSTR   = 4'd10
  } phase_e;

  typedef struct packed {
    phase_e                        phase;
    logic                          emit;
    logic [jtbs_pkg::TokW-1:0]     ttype;
  } begin_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  function automatic begin_t begin_tok(input logic [7:0] b);
    begin_t r;
    r.phase = PH_IDLE;
    r.emit  = 1'b0;
    r.ttype = jtbs_pkg::TOK_WS;
    case (b)
      jtbs_pkg::CH_SPACE, jtbs_pkg::CH_TAB: r.phase = PH_WS;
      jtbs_pkg::CH_LF: begin
        r.emit  = 1'b1;
        r.ttype = jtbs_pkg::TOK_NL;
      end
      jtbs_pkg::CH_CR: r.phase = PH_CR;
      jtbs_pkg::CH_LBRACK: begin
        r.emit  = 1'b1;
        r.ttype = jtbs_pkg::TOK_LBRACK;
      end
      jtbs_pkg::CH_RBRACK: begin
        r.emit  = 1'b1;
        r.ttype = jtbs_pkg::TOK_RBRACK;
      end
      jtbs_pkg::CH_LBRACE: begin
        r.emit  = 1'b1;
        r.ttype = jtbs_pkg::TOK_LBRACE;
      end
      jtbs_pkg::CH_RBRACE: begin
        r.emit  = 1'b1;
        r.ttype = jtbs_pkg::TOK_RBRACE;
      end
      jtbs_pkg::CH_COLON: begin
        r.emit  = 1'b1;
        r.ttype = jtbs_pkg::TOK_COLON;
      end
      jtbs_pkg::CH_COMMA: begin
        r.emit  = 1'b1;
        r.ttype = jtbs_pkg::TOK_COMMA;
      end
      jtbs_pkg::CH_QUOTE: r.phase = PH_QUOTES;
      jtbs_pkg::CH_SLASH: r.phase = PH_SLASH;
      default: r.phase = PH_VALUE;
    endcase
    return r;
  endfunction

  // input register
  logic               in_vld_q, in_vld_d;
  jtbs_pkg::in_beat_t in_q, in_d;

  // scanner state
  phase_e     ph_q, ph_d;
  logic [1:0] qr_q, qr_d;
  logic       esc_q, esc_d;
  logic       star_q, star_d;
  logic       clean_q, clean_d;

  // result queue
  jtbs_pkg::out_beat_t q_mem [QDepth];
  logic [QPtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]    cnt_q, cnt_d;

  logic proc, accept, pop;

  logic [7:0] b;
  begin_t     bt;
  logic       ctb, beg, idle, sb, sb_esc, sb_clean;
  logic [jtbs_pkg::TokW-1:0] ctb_type;
  logic       r0_v, r1_v;
  jtbs_pkg::out_beat_t r0, r1;

  assign proc        = in_vld_q && (cnt_q <= QCntW'(QDepth - 2));
  assign in_stall_o  = in_vld_q && !proc;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_beat_o  = q_mem[rd_ptr_q];

  always_comb begin
    b        = in_q.data_byte;
    bt       = begin_tok(b);
    ph_d     = ph_q;
    qr_d     = qr_q;
    esc_d    = esc_q;
    star_d   = star_q;
    clean_d  = clean_q;
    ctb      = 1'b0;
    ctb_type = jtbs_pkg::TOK_INVALID;
    beg      = 1'b0;
    idle     = 1'b0;
    sb       = 1'b0;
    sb_esc   = esc_q;
    sb_clean = clean_q;
    r0_v     = 1'b0;
    r1_v     = 1'b0;
    r0       = '{token_type: jtbs_pkg::TOK_INVALID, ends_before_byte: 1'b1, last: 1'b0};
    r1       = '{token_type: jtbs_pkg::TOK_INVALID, ends_before_byte: 1'b0, last: 1'b0};

    if (in_q.mode == jtbs_pkg::MODE_END) begin
      idle = 1'b1;
      if (ph_q != PH_IDLE) begin
        r0_v = 1'b1;
        unique case (ph_q)
          PH_WS:     r0.token_type = jtbs_pkg::TOK_WS;
          PH_CR:     r0.token_type = jtbs_pkg::TOK_NL;
          PH_VALUE:  r0.token_type = jtbs_pkg::TOK_VALUE;
          PH_LCOMM:  r0.token_type = jtbs_pkg::TOK_COMM;
          PH_QUOTES: r0.token_type = (qr_q == 2'd2) ? jtbs_pkg::TOK_STR
                                                    : jtbs_pkg::TOK_INVALID;
          PH_BSTR:   r0.token_type = (qr_q == jtbs_pkg::QUOTE_SAT) ? jtbs_pkg::TOK_BSTR
                                                                  : jtbs_pkg::TOK_INVALID;
          default:   r0.token_type = jtbs_pkg::TOK_INVALID;
        endcase
      end
    end else begin
      unique case (ph_q)
        PH_WS: begin
          if (b != jtbs_pkg::CH_SPACE && b != jtbs_pkg::CH_TAB) begin
            ctb      = 1'b1;
            ctb_type = jtbs_pkg::TOK_WS;
          end
        end
        PH_CR: begin
          if (b == jtbs_pkg::CH_LF) begin
            r0_v  = 1'b1;
            r0    = '{token_type: jtbs_pkg::TOK_NL, ends_before_byte: 1'b0, last: 1'b0};
            idle  = 1'b1;
          end else begin
            ctb      = 1'b1;
            ctb_type = jtbs_pkg::TOK_NL;
          end
        end
        PH_VALUE: begin
          if (jtbs_pkg::ends_value(b)) begin
            ctb      = 1'b1;
            ctb_type = jtbs_pkg::TOK_VALUE;
          end
        end
        PH_BADVAL: begin
          if (jtbs_pkg::ends_value(b)) begin
            ctb      = 1'b1;
            ctb_type = jtbs_pkg::TOK_INVALID;
          end
        end
        PH_SLASH: begin
          if (b == jtbs_pkg::CH_SLASH) begin
            ph_d = PH_LCOMM;
          end else if (b == jtbs_pkg::CH_STAR) begin
            ph_d   = PH_BCOMM;
            star_d = 1'b0;
          end else if (jtbs_pkg::ends_value(b)) begin
            ctb      = 1'b1;
            ctb_type = jtbs_pkg::TOK_INVALID;
          end else begin
            ph_d = PH_BADVAL;
          end
        end
        PH_LCOMM: begin
          if (b == jtbs_pkg::CH_CR || b == jtbs_pkg::CH_LF) begin
            ctb      = 1'b1;
            ctb_type = jtbs_pkg::TOK_COMM;
          end
        end
        PH_BCOMM: begin
          if (b == jtbs_pkg::CH_SLASH && star_q) begin
            r0_v = 1'b1;
            r0   = '{token_type: jtbs_pkg::TOK_BCOMM, ends_before_byte: 1'b0, last: 1'b0};
            idle = 1'b1;
          end else begin
            star_d = (b == jtbs_pkg::CH_STAR);
          end
        end
        PH_QUOTES: begin
          if (qr_q >= 2'd2) begin
            if (b == jtbs_pkg::CH_QUOTE) begin
              ph_d = PH_BSTR;
              qr_d = 2'd0;
            end else begin
              ctb      = 1'b1;
              ctb_type = jtbs_pkg::TOK_STR;
            end
          end else if (b == jtbs_pkg::CH_QUOTE) begin
            qr_d = 2'd2;
          end else begin
            ph_d     = PH_STR;
            qr_d     = 2'd0;
            esc_d    = 1'b0;
            clean_d  = 1'b1;
            sb       = 1'b1;
            sb_esc   = 1'b0;
            sb_clean = 1'b1;
          end
        end
        PH_STR: sb = 1'b1;
        PH_BSTR: begin
          if (b == jtbs_pkg::CH_QUOTE) begin
            if (qr_q != jtbs_pkg::QUOTE_SAT) qr_d = qr_q + 2'd1;
          end else if (qr_q != jtbs_pkg::QUOTE_SAT) begin
            qr_d = 2'd0;
          end else begin
            ctb      = 1'b1;
            ctb_type = jtbs_pkg::TOK_BSTR;
          end
        end
        default: beg = 1'b1;
      endcase
    end

    if (sb) begin
      if (b < jtbs_pkg::CTRL_LIMIT) begin
        if (b == jtbs_pkg::CH_LF) begin
          ctb      = 1'b1;
          ctb_type = jtbs_pkg::TOK_INVALID;
        end else begin
          clean_d = 1'b0;
        end
      end else if (sb_esc) begin
        esc_d = 1'b0;
      end else if (b == jtbs_pkg::CH_QUOTE) begin
        r0_v = 1'b1;
        r0   = '{token_type: sb_clean ? jtbs_pkg::TOK_STR : jtbs_pkg::TOK_INVALID,
                 ends_before_byte: 1'b0, last: 1'b0};
        idle = 1'b1;
      end else if (b == jtbs_pkg::CH_BSLASH) begin
        esc_d = 1'b1;
      end
    end

    if (idle) begin
      ph_d    = PH_IDLE;
      qr_d    = 2'd0;
      esc_d   = 1'b0;
      star_d  = 1'b0;
      clean_d = 1'b1;
    end

    if (ctb) begin
      r0_v = 1'b1;
      r0   = '{token_type: ctb_type, ends_before_byte: 1'b1, last: 1'b0};
    end

    if (ctb || beg) begin
      ph_d    = bt.phase;
      qr_d    = (b == jtbs_pkg::CH_QUOTE) ? 2'd1 : 2'd0;
      esc_d   = 1'b0;
      star_d  = 1'b0;
      clean_d = 1'b1;
      if (bt.emit) begin
        if (ctb) begin
          r1_v = 1'b1;
          r1   = '{token_type: bt.ttype, ends_before_byte: 1'b0, last: 1'b0};
        end else begin
          r0_v = 1'b1;
          r0   = '{token_type: bt.ttype, ends_before_byte: 1'b0, last: 1'b0};
        end
      end
    end

    if (r1_v) r1.last = 1'b1;
    else      r0.last = 1'b1;
  end

  always_comb begin
    in_vld_d = in_vld_q;
    in_d     = in_q;
    if (accept) begin
      in_vld_d = 1'b1;
      in_d     = in_beat_i;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (proc && r0_v) begin
      wr_ptr_d = wr_ptr_q + (r1_v ? QPtrW'(2) : QPtrW'(1));
      cnt_d    = cnt_q + (r1_v ? QCntW'(2) : QCntW'(1));
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + QPtrW'(1);
      cnt_d    = cnt_d - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      ph_q     <= PH_IDLE;
      qr_q     <= 2'd0;
      esc_q    <= 1'b0;
      star_q   <= 1'b0;
      clean_q  <= 1'b1;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      if (proc) begin
        ph_q    <= ph_d;
        qr_q    <= qr_d;
        esc_q   <= esc_d;
        star_q  <= star_d;
        clean_q <= clean_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_d;
    if (proc && r0_v) begin
      q_mem[wr_ptr_q] <= r0;
      if (r1_v) q_mem[wr_ptr_q + QPtrW'(1)] <= r1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue overfilled");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && r1_v |-> r0_v && r0.ends_before_byte && !r0.last && r1.last)
    else $error("second result without a closing first result");

  a_end_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_q.mode == jtbs_pkg::MODE_END |=> ph_q == PH_IDLE && !esc_q)
    else $error("end of input left a token open");

  a_escape_in_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> ph_q == PH_STR)
    else $error("escape pending outside a string");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && cnt_q > QCntW'(QDepth - 2))
    else $error("input stalled with room in the result queue");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the JSON token boundary scanner: random token streams, stalls.

typedef enum logic [3:0] {
  SCAN_IDLE, SCAN_WS, SCAN_CR, SCAN_VALUE, SCAN_SLASH, SCAN_LCOMM, SCAN_BCOMM,
  SCAN_BADVAL, SCAN_QUOTES, SCAN_STR, SCAN_BSTR
} scan_e;

class token_tracker;
  scan_e               phase;
  logic [1:0]          quote_cnt;
  logic                escaped;
  logic                star_prev;
  logic                clean;
  jtbs_pkg::out_beat_t step_tokens[$];
  jtbs_pkg::out_beat_t tokens_due[$];
  int                  mismatches;

  function new();
    clear_scan();
    mismatches = 0;
  endfunction

  static function bit value_stop(logic [7:0] b);
    bit r;
    case (b)
      jtbs_pkg::CH_TAB, jtbs_pkg::CH_LF, jtbs_pkg::CH_CR, jtbs_pkg::CH_SPACE,
      jtbs_pkg::CH_QUOTE, jtbs_pkg::CH_COMMA, jtbs_pkg::CH_COLON,
      jtbs_pkg::CH_LBRACK, jtbs_pkg::CH_RBRACK, jtbs_pkg::CH_LBRACE,
      jtbs_pkg::CH_RBRACE: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function void clear_scan();
    phase     = SCAN_IDLE;
    quote_cnt = 2'd0;
    escaped   = 1'b0;
    star_prev = 1'b0;
    clean     = 1'b1;
  endfunction

  function void emit(logic [3:0] tok, logic ends_early);
    jtbs_pkg::out_beat_t r;
    r.token_type       = tok;
    r.ends_before_byte = ends_early;
    r.last             = 1'b0;
    step_tokens.push_back(r);
  endfunction

  function void open_token(logic [7:0] b);
    clear_scan();
    case (b)
      jtbs_pkg::CH_SPACE, jtbs_pkg::CH_TAB: phase = SCAN_WS;
      jtbs_pkg::CH_LF:     emit(jtbs_pkg::TOK_NL, 1'b0);
      jtbs_pkg::CH_CR:     phase = SCAN_CR;
      jtbs_pkg::CH_LBRACK: emit(jtbs_pkg::TOK_LBRACK, 1'b0);
      jtbs_pkg::CH_RBRACK: emit(jtbs_pkg::TOK_RBRACK, 1'b0);
      jtbs_pkg::CH_LBRACE: emit(jtbs_pkg::TOK_LBRACE, 1'b0);
      jtbs_pkg::CH_RBRACE: emit(jtbs_pkg::TOK_RBRACE, 1'b0);
      jtbs_pkg::CH_COLON:  emit(jtbs_pkg::TOK_COLON, 1'b0);
      jtbs_pkg::CH_COMMA:  emit(jtbs_pkg::TOK_COMMA, 1'b0);
      jtbs_pkg::CH_QUOTE: begin
        phase     = SCAN_QUOTES;
        quote_cnt = 2'd1;
      end
      jtbs_pkg::CH_SLASH:  phase = SCAN_SLASH;
      default:             phase = SCAN_VALUE;
    endcase
  endfunction

  function void close_before(logic [3:0] tok, logic [7:0] b);
    emit(tok, 1'b1);
    open_token(b);
  endfunction

  function void in_string(logic [7:0] b);
    if (b < jtbs_pkg::CTRL_LIMIT) begin
      if (b == jtbs_pkg::CH_LF) close_before(jtbs_pkg::TOK_INVALID, b);
      else clean = 1'b0;
    end else if (escaped) begin
      escaped = 1'b0;
    end else if (b == jtbs_pkg::CH_QUOTE) begin
      emit(clean ? jtbs_pkg::TOK_STR : jtbs_pkg::TOK_INVALID, 1'b0);
      clear_scan();
    end else if (b == jtbs_pkg::CH_BSLASH) begin
      escaped = 1'b1;
    end
  endfunction

  function logic [3:0] closing_type();
    logic [3:0] r;
    case (phase)
      SCAN_WS:     r = jtbs_pkg::TOK_WS;
      SCAN_CR:     r = jtbs_pkg::TOK_NL;
      SCAN_VALUE:  r = jtbs_pkg::TOK_VALUE;
      SCAN_LCOMM:  r = jtbs_pkg::TOK_COMM;
      SCAN_QUOTES: r = (quote_cnt == 2'd2) ? jtbs_pkg::TOK_STR : jtbs_pkg::TOK_INVALID;
      SCAN_BSTR:   r = (quote_cnt == jtbs_pkg::QUOTE_SAT) ? jtbs_pkg::TOK_BSTR
                                                          : jtbs_pkg::TOK_INVALID;
      default:     r = jtbs_pkg::TOK_INVALID;
    endcase
    return r;
  endfunction

  function void take_byte(jtbs_pkg::in_beat_t beat);
    logic [7:0]          b;
    jtbs_pkg::out_beat_t r;
    b = beat.data_byte;
    step_tokens.delete();
    if (beat.mode == jtbs_pkg::MODE_END) begin
      if (phase != SCAN_IDLE) emit(closing_type(), 1'b1);
      clear_scan();
    end else begin
      case (phase)
        SCAN_WS: begin
          if (b != jtbs_pkg::CH_SPACE && b != jtbs_pkg::CH_TAB)
            close_before(jtbs_pkg::TOK_WS, b);
        end
        SCAN_CR: begin
          if (b == jtbs_pkg::CH_LF) begin
            emit(jtbs_pkg::TOK_NL, 1'b0);
            clear_scan();
          end else begin
            close_before(jtbs_pkg::TOK_NL, b);
          end
        end
        SCAN_VALUE:  if (value_stop(b)) close_before(jtbs_pkg::TOK_VALUE, b);
        SCAN_BADVAL: if (value_stop(b)) close_before(jtbs_pkg::TOK_INVALID, b);
        SCAN_SLASH: begin
          if (b == jtbs_pkg::CH_SLASH) begin
            phase = SCAN_LCOMM;
          end else if (b == jtbs_pkg::CH_STAR) begin
            phase     = SCAN_BCOMM;
            star_prev = 1'b0;
          end else if (value_stop(b)) begin
            close_before(jtbs_pkg::TOK_INVALID, b);
          end else begin
            phase = SCAN_BADVAL;
          end
        end
        SCAN_LCOMM: begin
          if (b == jtbs_pkg::CH_CR || b == jtbs_pkg::CH_LF)
            close_before(jtbs_pkg::TOK_COMM, b);
        end
        SCAN_BCOMM: begin
          if (b == jtbs_pkg::CH_SLASH && star_prev) begin
            emit(jtbs_pkg::TOK_BCOMM, 1'b0);
            clear_scan();
          end else begin
            star_prev = (b == jtbs_pkg::CH_STAR);
          end
        end
        SCAN_QUOTES: begin
          if (quote_cnt >= 2'd2) begin
            if (b == jtbs_pkg::CH_QUOTE) begin
              phase     = SCAN_BSTR;
              quote_cnt = 2'd0;
            end else begin
              close_before(jtbs_pkg::TOK_STR, b);
            end
          end else if (b == jtbs_pkg::CH_QUOTE) begin
            quote_cnt = 2'd2;
          end else begin
            phase     = SCAN_STR;
            quote_cnt = 2'd0;
            escaped   = 1'b0;
            clean     = 1'b1;
            in_string(b);
          end
        end
        SCAN_STR: in_string(b);
        SCAN_BSTR: begin
          if (b == jtbs_pkg::CH_QUOTE) begin
            if (quote_cnt < jtbs_pkg::QUOTE_SAT) quote_cnt = quote_cnt + 2'd1;
          end else if (quote_cnt < jtbs_pkg::QUOTE_SAT) begin
            quote_cnt = 2'd0;
          end else begin
            close_before(jtbs_pkg::TOK_BSTR, b);
          end
        end
        default: open_token(b);
      endcase
    end
    if (step_tokens.size() > 0) begin
      r      = step_tokens.pop_back();
      r.last = 1'b1;
      step_tokens.push_back(r);
    end
    foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
  endfunction

  function void match_token(jtbs_pkg::out_beat_t got);
    jtbs_pkg::out_beat_t want;
    if (tokens_due.size() == 0) begin
      $error("token_type: expected none, got %0d", got.token_type);
      mismatches++;
      return;
    end
    want = tokens_due.pop_front();
    if (got.token_type !== want.token_type) begin
      $error("token_type: expected %0d, got %0d", want.token_type, got.token_type);
      mismatches++;
    end
    if (got.ends_before_byte !== want.ends_before_byte) begin
      $error("ends_before_byte: expected %0d, got %0d",
             want.ends_before_byte, got.ends_before_byte);
      mismatches++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      mismatches++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget  = 450;
  localparam int QuietLimit  = 4000;
  localparam int DrainCycles = 8;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  jtbs_pkg::in_beat_t  in_beat   = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  jtbs_pkg::out_beat_t out_beat;

  token_tracker       tracker;
  jtbs_pkg::in_beat_t text_q[$];
  int                 burst_left  = 0;
  int                 beats_sent  = 0;
  int                 quiet_count = 0;
  int                 stall_style = 0;
  int                 style_left  = 0;

  json_token_boundary_scanner_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) tracker.take_byte(in_beat);
      if (out_valid && !out_stall) tracker.match_token(out_beat);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_count <= 0;
      else quiet_count <= quiet_count + 1;
    end
  end

  always @(negedge clk_i) begin
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 3);
      style_left  = $urandom_range(16, 96);
    end else begin
      style_left--;
    end
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  function automatic void add_byte(logic [7:0] b);
    jtbs_pkg::in_beat_t t;
    t.data_byte = b;
    t.mode      = jtbs_pkg::MODE_BYTE;
    text_q.push_back(t);
  endfunction

  function automatic void add_end();
    jtbs_pkg::in_beat_t t;
    t.data_byte = 8'($urandom_range(0, 255));
    t.mode      = jtbs_pkg::MODE_END;
    text_q.push_back(t);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (jtbs_pkg::ends_value(b) || b == jtbs_pkg::CH_SLASH || b == jtbs_pkg::CH_QUOTE);
    return b;
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(8'h20, 8'h7E));
    while (b == jtbs_pkg::CH_QUOTE || b == jtbs_pkg::CH_BSLASH);
    return b;
  endfunction

  function automatic void add_newline();
    case ($urandom_range(0, 2))
      0: add_byte(jtbs_pkg::CH_LF);
      1: add_byte(jtbs_pkg::CH_CR);
      default: begin
        add_byte(jtbs_pkg::CH_CR);
        add_byte(jtbs_pkg::CH_LF);
      end
    endcase
  endfunction

  function automatic void add_token();
    logic [7:0] b;
    case ($urandom_range(0, 15))
      0, 1: begin
        repeat ($urandom_range(1, 3))
          add_byte($urandom_range(0, 1) ? jtbs_pkg::CH_SPACE : jtbs_pkg::CH_TAB);
      end
      2: add_newline();
      3, 4: begin
        case ($urandom_range(0, 5))
          0: add_byte(jtbs_pkg::CH_LBRACK);
          1: add_byte(jtbs_pkg::CH_RBRACK);
          2: add_byte(jtbs_pkg::CH_LBRACE);
          3: add_byte(jtbs_pkg::CH_RBRACE);
          4: add_byte(jtbs_pkg::CH_COLON);
          default: add_byte(jtbs_pkg::CH_COMMA);
        endcase
      end
      5, 6: begin
        add_byte(plain_byte());
        repeat ($urandom_range(0, 4))
          add_byte(($urandom_range(0, 3) == 0) ? jtbs_pkg::CH_SLASH : plain_byte());
      end
      7, 8: begin
        add_byte(jtbs_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 7))
            0: begin
              add_byte(jtbs_pkg::CH_BSLASH);
              add_byte(($urandom_range(0, 2) == 0) ? jtbs_pkg::CH_QUOTE : text_byte());
            end
            1: begin
              do b = 8'($urandom_range(0, 31));
              while (b == jtbs_pkg::CH_LF);
              add_byte(b);
            end
            2: add_byte(8'($urandom_range(8'h80, 8'hFF)));
            default: add_byte(text_byte());
          endcase
        end
        add_byte(jtbs_pkg::CH_QUOTE);
      end
      9: begin
        repeat (3) add_byte(jtbs_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) add_byte(jtbs_pkg::CH_QUOTE);
          do b = 8'($urandom_range(0, 255));
          while (b == jtbs_pkg::CH_QUOTE);
          add_byte(b);
        end
        repeat ($urandom_range(3, 5)) add_byte(jtbs_pkg::CH_QUOTE);
      end
      10: begin
        add_byte(jtbs_pkg::CH_SLASH);
        add_byte(jtbs_pkg::CH_SLASH);
        repeat ($urandom_range(0, 5)) begin
          do b = 8'($urandom_range(0, 255));
          while (b == jtbs_pkg::CH_CR || b == jtbs_pkg::CH_LF);
          add_byte(b);
        end
        add_newline();
      end
      11: begin
        add_byte(jtbs_pkg::CH_SLASH);
        add_byte(jtbs_pkg::CH_STAR);
        repeat ($urandom_range(0, 5))
          add_byte(($urandom_range(0, 2) == 0) ? jtbs_pkg::CH_STAR
                                               : 8'($urandom_range(0, 255)));
        add_byte(jtbs_pkg::CH_STAR);
        add_byte(jtbs_pkg::CH_SLASH);
      end
      12: begin
        add_byte(jtbs_pkg::CH_SLASH);
        repeat ($urandom_range(0, 3)) begin
          do b = plain_byte();
          while (b == jtbs_pkg::CH_STAR);
          add_byte(b);
        end
      end
      13: add_end();
      14: repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
      default: begin
        case ($urandom_range(0, 3))
          0: begin
            add_byte(jtbs_pkg::CH_QUOTE);
            add_byte(text_byte());
            add_byte(jtbs_pkg::CH_LF);
          end
          1: begin
            add_byte(jtbs_pkg::CH_QUOTE);
            if ($urandom_range(0, 1)) add_byte(text_byte());
            add_end();
          end
          2: begin
            add_byte(jtbs_pkg::CH_SLASH);
            add_end();
          end
          default: begin
            add_byte(jtbs_pkg::CH_SLASH);
            add_byte(jtbs_pkg::CH_STAR);
            add_byte(text_byte());
            add_end();
          end
        endcase
      end
    endcase
  endfunction

  function automatic void add_directed();
    add_byte(jtbs_pkg::CH_CR);
    add_byte(jtbs_pkg::CH_LF);
    add_byte(jtbs_pkg::CH_CR);
    add_byte(jtbs_pkg::CH_LBRACK);
    add_byte(jtbs_pkg::CH_RBRACK);
    add_byte(jtbs_pkg::CH_QUOTE);
    add_byte(jtbs_pkg::CH_QUOTE);
    add_byte(8'hFF);
    add_byte(jtbs_pkg::CH_SLASH);
    add_byte(jtbs_pkg::CH_TAB);
    add_byte(jtbs_pkg::CH_SLASH);
    add_byte(8'h78);
    add_byte(jtbs_pkg::CH_SPACE);
    add_byte(jtbs_pkg::CH_QUOTE);
    add_byte(8'h00);
    add_byte(jtbs_pkg::CH_QUOTE);
    add_byte(jtbs_pkg::CH_QUOTE);
    add_byte(8'h61);
    add_byte(jtbs_pkg::CH_LF);
    add_byte(jtbs_pkg::CH_SLASH);
    add_byte(jtbs_pkg::CH_STAR);
    add_byte(jtbs_pkg::CH_STAR);
    add_byte(jtbs_pkg::CH_SLASH);
    repeat (6) add_byte(jtbs_pkg::CH_QUOTE);
    add_end();
  endfunction

  task automatic send_beat(input jtbs_pkg::in_beat_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(24, 48) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic send_text();
    while (text_q.size() > 0) begin
      send_beat(text_q.pop_front());
      beats_sent++;
    end
  endtask

  initial begin
    @(posedge clk_i);
    while (quiet_count < QuietLimit) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    tracker = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    add_directed();
    send_text();
    while (beats_sent < ItemTarget) begin
      add_token();
      send_text();
    end
    add_end();
    send_text();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (tracker.tokens_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
